[src/scr_pkg.sv]
// scr_pkg: shared constants, codes, keyword table and types of the
// serial command recognizer. Depends on nothing.
package scr_pkg;

   // line store geometry
   localparam int LINE_MAX   = 32;
   localparam int COUNT_W    = $clog2(LINE_MAX);
   localparam int LEN_W      = 5;
   localparam int BYTE_W     = 8;
   localparam int CMD_W      = 3;

   // keyword table geometry
   localparam int KEY_COUNT  = 6;
   localparam int KEY_MAXLEN = 5;
   localparam int KEY_IDX_W  = $clog2(KEY_MAXLEN);

   // command codes
   localparam logic [CMD_W-1:0] CMD_TASK1   = 3'd0;
   localparam logic [CMD_W-1:0] CMD_TASK2   = 3'd1;
   localparam logic [CMD_W-1:0] CMD_TASK3   = 3'd2;
   localparam logic [CMD_W-1:0] CMD_PING    = 3'd3;
   localparam logic [CMD_W-1:0] CMD_MRST    = 3'd4;
   localparam logic [CMD_W-1:0] CMD_ADC     = 3'd5;
   localparam logic [CMD_W-1:0] CMD_UNKNOWN = 3'd6;

   // character codes
   localparam logic [BYTE_W-1:0] CHAR_NEWLINE = 8'd10;
   localparam logic [BYTE_W-1:0] CHAR_SPACE   = 8'd32;
   localparam logic [BYTE_W-1:0] CHAR_UPPER_A = 8'd65;
   localparam logic [BYTE_W-1:0] CHAR_UPPER_Z = 8'd90;
   localparam logic [BYTE_W-1:0] CASE_OFFSET  = 8'd32;

   // head of the current line and its length
   typedef struct packed {
      logic [COUNT_W-1:0]                count;
      logic [KEY_MAXLEN-1:0][BYTE_W-1:0] chars;
   } line_type;

   // keyword lengths
   function automatic int key_len(input int k);
      int n;
      case (k)
         0, 1, 2: n = 5;
         3, 4:    n = 4;
         5:       n = 3;
         default: n = 0;
      endcase
      return n;
   endfunction

   // keyword characters, lower case
   function automatic logic [BYTE_W-1:0] key_char(input int k, input int i);
      logic [KEY_MAXLEN*BYTE_W-1:0] text;
      case (k)
         0:       text = "task1";
         1:       text = "task2";
         2:       text = "task3";
         3:       text = {"ping", 8'd0};
         4:       text = {"mrst", 8'd0};
         5:       text = {"adc", 16'd0};
         default: text = '0;
      endcase
      return text[(KEY_MAXLEN-1-i)*BYTE_W +: BYTE_W];
   endfunction

   // keyword index to command code
   function automatic logic [CMD_W-1:0] key_code(input int k);
      logic [CMD_W-1:0] code;
      case (k)
         0:       code = CMD_TASK1;
         1:       code = CMD_TASK2;
         2:       code = CMD_TASK3;
         3:       code = CMD_PING;
         4:       code = CMD_MRST;
         5:       code = CMD_ADC;
         default: code = CMD_UNKNOWN;
      endcase
      return code;
   endfunction

endpackage

[src/scr_req_if.sv]
// scr_req_if: received byte channel, valid/ready with one byte per word.
// Depends on scr_pkg.
interface scr_req_if;
   logic                         valid;
   logic                         ready;
   logic [scr_pkg::BYTE_W-1:0]   rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

[src/scr_rsp_if.sv]
// scr_rsp_if: result channel, valid/ready with command code and line length.
// Depends on scr_pkg.
interface scr_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [scr_pkg::CMD_W-1:0]    command;
   logic [scr_pkg::LEN_W-1:0]    line_length;

   modport source (output valid, output command, output line_length, input ready);
   modport sink   (input valid, input command, input line_length, output ready);
endinterface

[src/scr_line_buffer.sv]
// scr_line_buffer: character count and line store of the current line.
// Depends on scr_pkg.
module scr_line_buffer (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         advance,
   input  logic [scr_pkg::BYTE_W-1:0]   rx_byte,
   output scr_pkg::line_type            line
);

   logic [scr_pkg::COUNT_W-1:0]                        count_ff, count_in;
   logic [scr_pkg::KEY_MAXLEN-1:0][scr_pkg::BYTE_W-1:0] chars_ff;
   logic [scr_pkg::BYTE_W-1:0]                         lowered;
   logic                                               printable;
   logic                                               full;
   logic                                               store_en;

   // classify the byte
   always_comb begin
      printable = rx_byte > scr_pkg::CHAR_SPACE;
      full      = count_ff >= scr_pkg::COUNT_W'(scr_pkg::LINE_MAX - 1);
      if (rx_byte >= scr_pkg::CHAR_UPPER_A && rx_byte <= scr_pkg::CHAR_UPPER_Z) begin
         lowered = rx_byte + scr_pkg::CASE_OFFSET;
      end else begin
         lowered = rx_byte;
      end
   end

   // next count
   always_comb begin
      count_in = count_ff;
      store_en = 1'b0;
      if (advance) begin
         if (rx_byte == scr_pkg::CHAR_NEWLINE) begin
            count_in = '0;
         end else if (printable) begin
            if (full) begin
               count_in = '0;
            end else begin
               count_in = count_ff + 1'b1;
               store_en = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   // only the head of the line can take part in a keyword match, so only
   // that many characters are kept
   always_ff @(posedge clock) begin
      if (store_en && count_ff < scr_pkg::COUNT_W'(scr_pkg::KEY_MAXLEN)) begin
         chars_ff[count_ff[scr_pkg::KEY_IDX_W-1:0]] <= lowered;
      end
   end

   assign line.count = count_ff;
   assign line.chars = chars_ff;

endmodule

[src/scr_keyword_match.sv]
// scr_keyword_match: compares the stored line with the keyword table.
// Depends on scr_pkg.
module scr_keyword_match (
   input  scr_pkg::line_type            line,
   output logic [scr_pkg::CMD_W-1:0]    command
);

   logic [scr_pkg::KEY_COUNT-1:0] hit;

   // one compare per keyword, over at most the keyword length
   always_comb begin
      for (int k = 0; k < scr_pkg::KEY_COUNT; k++) begin
         hit[k] = line.count == scr_pkg::COUNT_W'(scr_pkg::key_len(k));
         for (int i = 0; i < scr_pkg::KEY_MAXLEN; i++) begin
            if (i < scr_pkg::key_len(k) && line.chars[i] != scr_pkg::key_char(k, i)) begin
               hit[k] = 1'b0;
            end
         end
      end
   end

   // lowest keyword wins
   always_comb begin
      command = scr_pkg::CMD_UNKNOWN;
      for (int k = scr_pkg::KEY_COUNT - 1; k >= 0; k--) begin
         if (hit[k]) begin
            command = scr_pkg::key_code(k);
         end
      end
   end

endmodule

[src/serial_command_recognizer.sv]
// serial_command_recognizer: top level, input word register, line buffer,
// keyword match and result register. Depends on scr_pkg, scr_req_if,
// scr_rsp_if, scr_line_buffer and scr_keyword_match.
//
//   channel  direction  fields
//   req      in         rx_byte[7:0]
//   rsp      out        command[2:0], line_length[4:0] (one word per newline)
//
// One byte is taken every cycle while not stalled; a result passes the input
// word register, then the result register, which holds the answer. The input
// word register feeds the line buffer update and the keyword compare at once.
// Reset is synchronous and clears the count and both valid flags at once.
// A stalled result holds only a newline behind it; other bytes keep flowing.
module serial_command_recognizer (
   input  logic            clock,
   input  logic            reset,
   scr_req_if.sink         req,
   scr_rsp_if.source       rsp
);

   logic                         in_valid_ff, in_valid_in;
   logic [scr_pkg::BYTE_W-1:0]   in_byte_ff;
   logic                         out_valid_ff, out_valid_in;
   logic [scr_pkg::CMD_W-1:0]    out_cmd_ff;
   logic [scr_pkg::LEN_W-1:0]    out_len_ff;
   logic                         is_newline;
   logic                         advance;
   logic                         emit;
   logic [scr_pkg::CMD_W-1:0]    match_cmd;
   scr_pkg::line_type            line;

   // handshake control
   always_comb begin
      is_newline   = in_byte_ff == scr_pkg::CHAR_NEWLINE;
      advance      = in_valid_ff && (!is_newline || !out_valid_ff || rsp.ready);
      emit         = advance && is_newline;
      req.ready    = !in_valid_ff || advance;
      in_valid_in  = req.valid ? 1'b1 : (in_valid_ff && !advance);
      out_valid_in = emit ? 1'b1 : (out_valid_ff && !rsp.ready);
   end

   // input word register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req.ready) begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req.valid && req.ready) begin
         in_byte_ff <= req.rx_byte;
      end
   end

   scr_line_buffer u_line_buffer (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .rx_byte (in_byte_ff),
      .line    (line)
   );

   scr_keyword_match u_keyword_match (
      .line    (line),
      .command (match_cmd)
   );

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         out_cmd_ff <= match_cmd;
         out_len_ff <= scr_pkg::LEN_W'(line.count);
      end
   end

   assign rsp.valid       = out_valid_ff;
   assign rsp.command     = out_cmd_ff;
   assign rsp.line_length = out_len_ff;

   // input stalls only behind a newline blocked by a full result register
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req.ready |-> (in_valid_ff && is_newline && out_valid_ff && !rsp.ready))
      else $error("input stalled without a blocked newline");

   // count stays below the store size
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      line.count <= scr_pkg::COUNT_W'(scr_pkg::LINE_MAX - 1))
      else $error("character count beyond store size");

   // a processed newline always shows a result next cycle
   a_newline_result: assert property (@(posedge clock) disable iff (reset)
      emit |=> rsp.valid)
      else $error("newline gave no result");

   // result code is a keyword or unknown
   a_code_range: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> rsp.command <= scr_pkg::CMD_UNKNOWN)
      else $error("result code out of range");

endmodule
